@@ src/srde_pkg.sv @@
// Shared types and constants for the signed radix digit emitter.
// No dependencies; imported by signed_radix_digit_emitter_top.
package srde_pkg;

  // Character codes with a fixed meaning.
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_NUL   = 8'd0;

  // Symbol table geometry.
  localparam int SYM_SLOTS = 16;

  // Digit store geometry.
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = STORE_AW + 1;

  // Dividend bits handled by the shared divide unit in one clock.
  localparam int DIV_BITS = 8;

  // Defaults for the top level parameters.
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [4:0]  BASE_LEN_RST     = 5'd10;
  localparam logic [63:0] SYMBOLS_LOW_RST  = 64'd3978425819141910832;
  localparam logic [63:0] SYMBOLS_HIGH_RST = 64'd14648;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERROR,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

@@ src/signed_radix_digit_emitter_top.sv @@
// Top level of the signed radix digit emitter: symbol table check, shared
// divide unit, digit store and output register. Depends on srde_pkg.

// The block takes one signed value per transfer on the s_ side and sends its
// text, one character per transfer on the m_ side, most significant digit
// first. A negative value starts with '-', and its digits come from the
// magnitude, so the most negative value converts correctly. Zero gives the
// single symbol 0. The radix is base_len and the digit symbols are the first
// base_len bytes of {symbols_high, symbols_low}. If that table is unusable
// (fewer than two symbols, more than MAX_SYMBOLS, a zero byte, '+', '-' or a
// repeated symbol) one transfer with m_tuser high, m_tlast high and a zero
// character is sent instead. m_tlast marks the last character of each value.
// Flow: s_tready is high only while the sequencer is idle. An item is
// accepted, then its symbols are checked one at a time (up to base_len,
// fewer when a bad symbol is found early), then the divide unit makes the
// digits, each from one pass over the padded dividend, then the characters
// are sent, waiting while the output is stalled. The divide unit is the
// bottleneck: it takes eight dividend bits per clock through a chain of
// compare-subtract steps. The last character of an item may still wait in
// the output register while the next item is accepted.
// Configuration writes are applied at once and must only be made while no
// item is in flight.
module signed_radix_digit_emitter_top #(
  parameter int MAX_SYMBOLS = srde_pkg::MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = srde_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [srde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srde_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // [31:0] value
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] char_out
  output logic                            m_tlast,   // is_last
  output logic                            m_tuser    // [0] bad_base
);
  import srde_pkg::*;

  // The dividend register is padded up to whole divide steps; the extra
  // leading zeros do not change quotient or remainder.
  localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W     = DIV_STEPS * DIV_BITS;
  localparam int DSTEP_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [DSTEP_W-1:0] DSTEP_LAST = DSTEP_W'(DIV_STEPS - 1);
  localparam logic [4:0]         MAX_SYM_L  = 5'(MAX_SYMBOLS);
  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(STORE_DEPTH - 1);

  // Configuration registers.
  logic [4:0]  base_len;
  logic [63:0] symbols_low;
  logic [63:0] symbols_high;

  // Sequencer and working registers.
  state_t               state, state_next;
  logic [3:0]           check_idx;
  logic [PAD_W-1:0]     mag;
  logic                 neg;
  logic [3:0]           rem;
  logic [DSTEP_W-1:0]   dstep;
  logic [COUNT_W-1:0]   digit_count;
  logic [3:0]           digit_store [STORE_DEPTH];

  // Output register.
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;
  logic       out_bad;
  logic       out_free;
  logic       out_load;
  logic [7:0] out_char_next;
  logic       out_last_next;
  logic       out_bad_next;

  // Symbol table viewed as sixteen bytes, symbol 0 in the low byte.
  logic [SYM_SLOTS-1:0][7:0] sym_tab;
  assign sym_tab = {symbols_high, symbols_low};

  // Input conversion: sign and magnitude of the low VALUE_BITS bits.
  logic [VALUE_BITS-1:0] raw_value;
  logic                  raw_neg;
  logic [VALUE_BITS-1:0] raw_mag;

  always_comb begin
    raw_value = s_tdata[VALUE_BITS-1:0];
    raw_neg   = raw_value[VALUE_BITS-1];
    raw_mag   = raw_neg ? (~raw_value + VALUE_BITS'(1)) : raw_value;
  end

  // Symbol check: one symbol a cycle against every later symbol in use.
  logic [7:0] cur_sym;
  logic       range_bad;
  logic       sym_bad;
  logic       check_end;

  always_comb begin
    cur_sym   = sym_tab[check_idx];
    range_bad = (base_len < 5'd2) || (base_len > MAX_SYM_L);
    sym_bad   = (cur_sym == CH_NUL) || (cur_sym == CH_MINUS) || (cur_sym == CH_PLUS);
    for (int j = 0; j < SYM_SLOTS; j++) begin
      if ((5'(j) > {1'b0, check_idx}) && (5'(j) < base_len) && (sym_tab[j] == cur_sym)) begin
        sym_bad = 1'b1;
      end
    end
    check_end = ({1'b0, check_idx} == (base_len - 5'd1));
  end

  // Shared divide unit: restoring division of the top DIV_BITS dividend
  // bits by the radix, quotient bits shifted in at the bottom.
  logic [DIV_BITS-1:0] div_top;
  logic [DIV_BITS-1:0] qbits;
  logic [4:0]          trial;
  logic [3:0]          rem_out;
  logic [PAD_W-1:0]    mag_shift;
  logic                step_last;
  logic                quot_zero;

  always_comb begin
    div_top = mag[PAD_W-1 -: DIV_BITS];
    rem_out = rem;
    qbits   = '0;
    trial   = '0;
    for (int b = DIV_BITS - 1; b >= 0; b--) begin
      trial = {rem_out, div_top[b]};
      if (trial >= base_len) begin
        trial    = trial - base_len;
        qbits[b] = 1'b1;
      end
      rem_out = trial[3:0];
    end
    mag_shift = (mag << DIV_BITS) | PAD_W'(qbits);
    step_last = (dstep == DSTEP_LAST);
    quot_zero = (mag_shift == '0);
  end

  // Digit readout, most significant digit first.
  logic [STORE_AW-1:0] rd_idx;
  assign rd_idx   = STORE_AW'(digit_count - COUNT_W'(1));
  assign out_free = !out_valid || m_tready;

  // Sequencer: next state and output loads.
  always_comb begin
    state_next    = state;
    out_load      = 1'b0;
    out_char_next = CH_NUL;
    out_last_next = 1'b0;
    out_bad_next  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (range_bad || sym_bad) begin
          state_next = ST_ERROR;
        end else if (check_end) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_last_next = 1'b1;
          out_bad_next  = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (step_last && (quot_zero || digit_count == COUNT_LAST)) begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_next = CH_MINUS;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_next = sym_tab[digit_store[rd_idx]];
          out_last_next = (digit_count == COUNT_W'(1));
          if (out_last_next) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      base_len    <= BASE_LEN_RST;
      symbols_low <= SYMBOLS_LOW_RST;
      symbols_high <= SYMBOLS_HIGH_RST;
      check_idx   <= '0;
      mag         <= '0;
      neg         <= 1'b0;
      rem         <= '0;
      dstep       <= '0;
      digit_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_LEN:     base_len     <= cfg_data[4:0];
          REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
          REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mag       <= PAD_W'(raw_mag);
            neg       <= raw_neg;
            check_idx <= '0;
          end
        end
        ST_CHECK: begin
          check_idx   <= check_idx + 4'd1;
          rem         <= '0;
          dstep       <= '0;
          digit_count <= '0;
        end
        ST_DIVIDE: begin
          mag <= mag_shift;
          if (step_last) begin
            dstep       <= '0;
            rem         <= '0;
            digit_count <= digit_count + COUNT_W'(1);
          end else begin
            dstep <= dstep + DSTEP_W'(1);
            rem   <= rem_out;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            digit_count <= digit_count - COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= out_char_next;
      out_last <= out_last_next;
      out_bad  <= out_bad_next;
    end
    if (state == ST_DIVIDE && step_last) begin
      digit_store[digit_count[STORE_AW-1:0]] <= rem_out;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tlast  = out_last;
  assign m_tuser  = out_bad;

  // An error result is always a single, closing transfer with no character.
  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == CH_NUL))
    else $error("error result not marked last or carries a character");

  // The digit count never runs past the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_W'(STORE_DEPTH))
    else $error("digit count exceeds store depth");

  // Readout only runs while digits remain.
  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (digit_count != '0))
    else $error("readout with no digit left");

  // A sign is only sent for a negative value, followed by the digits.
  a_sign_then_digits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN && out_free) |=> (state == ST_EMIT && neg))
    else $error("sign not followed by digit readout");

endmodule
